// ----- hdl/rtcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types and constants of the ratio tap changer controller.
// ----------------------------------------------------------------------------
package rtcc_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // tap limits
  localparam logic signed [7:0] LOW_TAP       = 8'sd0;
  localparam logic signed [7:0] HIGH_TAP      = 8'sd31;
  localparam logic signed [7:0] TAP_REF_RESET = -8'sd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TARGET_VOLTAGE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DELAY       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_NEXT_DELAY        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_TAP       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REGULATING        = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UP_RAISES_VOLTAGE = 3'd6;

  // 0.015 pu in 1/16384 steps
  localparam logic [13:0] TOLERANCE_RESET = 14'd246;

  typedef enum logic [1:0] {
    BAND_IN    = 2'd0,
    BAND_ABOVE = 2'd1,
    BAND_BELOW = 2'd2
  } band_t;

  typedef struct packed {
    logic [15:0] target_voltage;
    logic [13:0] tolerance;
    logic [23:0] first_delay;
    logic [23:0] next_delay;
    logic        regulating;
    logic        up_raises_voltage;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic signed [7:0] value;
  } tap_load_t;

  typedef struct packed {
    logic [31:0]        now;
    logic [15:0]        voltage;
    logic signed [15:0] target_offset;
    logic               node_off;
    logic               disabled;
    logic               locked;
    logic               transformer_closed;
    logic               events_off;
  } item_t;

  typedef struct packed {
    logic above;
    logic below;
  } band_flags_t;

  typedef struct packed {
    logic signed [7:0] tap_position;
    logic              tap_raised;
    logic              tap_lowered;
    band_t             band_status;
  } result_t;

endpackage

// ----- hdl/rtcc_cfg.sv -----
// ----------------------------------------------------------------------------
// rtcc_cfg
// Configuration register file with tap preload strobe.
// ----------------------------------------------------------------------------
module rtcc_cfg import rtcc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg,
  output tap_load_t           tap_load
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt        = cfg_r;
    tap_load.load  = 1'b0;
    tap_load.value = $signed(wr_data[7:0]);
    if (wr_en) begin
      unique case (wr_index)
        CFG_TARGET_VOLTAGE:    cfg_nxt.target_voltage    = wr_data[15:0];
        CFG_TOLERANCE:         cfg_nxt.tolerance         = wr_data[13:0];
        CFG_FIRST_DELAY:       cfg_nxt.first_delay       = wr_data[23:0];
        CFG_NEXT_DELAY:        cfg_nxt.next_delay        = wr_data[23:0];
        CFG_INITIAL_TAP:       tap_load.load             = 1'b1;
        CFG_REGULATING:        cfg_nxt.regulating        = wr_data[0];
        CFG_UP_RAISES_VOLTAGE: cfg_nxt.up_raises_voltage = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_voltage    <= '0;
      cfg_r.tolerance         <= TOLERANCE_RESET;
      cfg_r.first_delay       <= '0;
      cfg_r.next_delay        <= '0;
      cfg_r.regulating        <= 1'b1;
      cfg_r.up_raises_voltage <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/rtcc_band.sv -----
// ----------------------------------------------------------------------------
// rtcc_band
// Dead band comparator: above and below band with qualifiers.
// ----------------------------------------------------------------------------
module rtcc_band import rtcc_pkg::*; (
  input  cfg_t        cfg,
  input  item_t       item,
  output band_flags_t flags
);

  logic signed [18:0] upper;
  logic signed [18:0] lower;
  logic signed [18:0] volt;
  logic               qual;

  always_comb begin
    volt  = $signed({3'b000, item.voltage});
    upper = $signed({3'b000, cfg.target_voltage}) + $signed({5'b00000, cfg.tolerance})
          + $signed({{3{item.target_offset[15]}}, item.target_offset});
    lower = $signed({3'b000, cfg.target_voltage}) - $signed({5'b00000, cfg.tolerance})
          + $signed({{3{item.target_offset[15]}}, item.target_offset});
    qual  = !item.disabled && !item.node_off && item.transformer_closed;
    flags.above = qual && (volt > upper);
    flags.below = qual && (volt < lower);
  end

endmodule

// ----- hdl/rtcc_core.sv -----
// ----------------------------------------------------------------------------
// rtcc_core
// Regulator state, tap due conditions and one-step state update.
// ----------------------------------------------------------------------------
module rtcc_core import rtcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  item_t       item,
  input  cfg_t        cfg,
  input  band_flags_t flags,
  input  tap_load_t   tap_load,
  output result_t     result
);

  logic signed [7:0] tap_now_r, tap_now_nxt;
  logic [31:0]       up_start_r, up_start_nxt;
  logic              up_start_set_r, up_start_set_nxt;
  logic [31:0]       down_start_r, down_start_nxt;
  logic              down_start_set_r, down_start_set_nxt;
  logic [31:0]       last_move_r, last_move_nxt;
  logic              last_move_set_r, last_move_set_nxt;
  logic              going_up_r, going_up_nxt;
  logic              going_down_r, going_down_nxt;
  logic signed [7:0] up_ref_r, up_ref_nxt;
  logic signed [7:0] down_ref_r, down_ref_nxt;
  band_t             band_r, band_nxt;

  logic        live, allow, gate;
  logic        up_first_ok, down_first_ok, next_ok;
  logic        up_due, down_due;
  logic        start_up, start_down;
  logic [31:0] up_diff, down_diff, move_diff;

  always_comb begin
    live      = !item.node_off && item.transformer_closed;
    allow     = !item.locked && cfg.regulating && live;
    gate      = !item.disabled && live && !item.locked && !item.events_off;
    up_diff   = item.now - up_start_r;
    down_diff = item.now - down_start_r;
    move_diff = item.now - last_move_r;

    up_first_ok   = up_start_set_r && (up_diff >= {8'd0, cfg.first_delay});
    down_first_ok = down_start_set_r && (down_diff >= {8'd0, cfg.first_delay});
    next_ok       = last_move_set_r && (move_diff >= {8'd0, cfg.next_delay});

    up_due = going_up_r && allow && (tap_now_r < HIGH_TAP)
          && ((tap_now_r == up_ref_r && up_first_ok) || (tap_now_r != up_ref_r && next_ok));
    down_due = going_down_r && allow && (tap_now_r > LOW_TAP)
            && ((tap_now_r == down_ref_r && down_first_ok)
                || (tap_now_r != down_ref_r && next_ok));

    start_up   = (flags.above && band_r != BAND_ABOVE && !cfg.up_raises_voltage)
              || (flags.below && band_r != BAND_BELOW && cfg.up_raises_voltage);
    start_down = (flags.above && band_r != BAND_ABOVE && cfg.up_raises_voltage)
              || (flags.below && band_r != BAND_BELOW && !cfg.up_raises_voltage);

    tap_now_nxt        = tap_now_r;
    up_start_nxt       = up_start_r;
    up_start_set_nxt   = up_start_set_r;
    down_start_nxt     = down_start_r;
    down_start_set_nxt = down_start_set_r;
    last_move_nxt      = last_move_r;
    last_move_set_nxt  = last_move_set_r;
    going_up_nxt       = going_up_r;
    going_down_nxt     = going_down_r;
    up_ref_nxt         = up_ref_r;
    down_ref_nxt       = down_ref_r;
    band_nxt           = band_r;
    result.tap_raised  = 1'b0;
    result.tap_lowered = 1'b0;

    if (gate) begin
      if (start_up) begin
        up_start_nxt       = item.now;
        up_start_set_nxt   = 1'b1;
        going_up_nxt       = 1'b1;
        up_ref_nxt         = tap_now_r;
        down_start_nxt     = '0;
        down_start_set_nxt = 1'b0;
        going_down_nxt     = 1'b0;
        down_ref_nxt       = HIGH_TAP;
      end
      if (start_down) begin
        down_start_nxt     = item.now;
        down_start_set_nxt = 1'b1;
        going_down_nxt     = 1'b1;
        down_ref_nxt       = tap_now_r;
        up_start_nxt       = '0;
        up_start_set_nxt   = 1'b0;
        going_up_nxt       = 1'b0;
        up_ref_nxt         = LOW_TAP;
      end
      if (flags.above && band_r != BAND_ABOVE) begin
        band_nxt = BAND_ABOVE;
      end else if (flags.below && band_r != BAND_BELOW) begin
        band_nxt = BAND_BELOW;
      end else if (!flags.above && !flags.below && band_r != BAND_IN) begin
        up_start_nxt       = '0;
        up_start_set_nxt   = 1'b0;
        going_up_nxt       = 1'b0;
        up_ref_nxt         = LOW_TAP;
        down_start_nxt     = '0;
        down_start_set_nxt = 1'b0;
        going_down_nxt     = 1'b0;
        down_ref_nxt       = HIGH_TAP;
        band_nxt           = BAND_IN;
      end
      tap_now_nxt = tap_now_r + $signed({7'd0, up_due}) - $signed({7'd0, down_due});
      if (up_due || down_due) begin
        last_move_nxt     = item.now;
        last_move_set_nxt = 1'b1;
      end
      result.tap_raised  = up_due;
      result.tap_lowered = down_due;
    end

    result.tap_position = tap_now_nxt;
    result.band_status  = band_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_now_r        <= 8'sd0;
      up_start_r       <= '0;
      up_start_set_r   <= 1'b0;
      down_start_r     <= '0;
      down_start_set_r <= 1'b0;
      last_move_r      <= '0;
      last_move_set_r  <= 1'b0;
      going_up_r       <= 1'b0;
      going_down_r     <= 1'b0;
      up_ref_r         <= TAP_REF_RESET;
      down_ref_r       <= TAP_REF_RESET;
      band_r           <= BAND_IN;
    end else begin
      if (tap_load.load) begin
        tap_now_r <= tap_load.value;
      end else if (step) begin
        tap_now_r <= tap_now_nxt;
      end
      if (step) begin
        up_start_r       <= up_start_nxt;
        up_start_set_r   <= up_start_set_nxt;
        down_start_r     <= down_start_nxt;
        down_start_set_r <= down_start_set_nxt;
        last_move_r      <= last_move_nxt;
        last_move_set_r  <= last_move_set_nxt;
        going_up_r       <= going_up_nxt;
        going_down_r     <= going_down_nxt;
        up_ref_r         <= up_ref_nxt;
        down_ref_r       <= down_ref_nxt;
        band_r           <= band_nxt;
      end
    end
  end

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    !(going_up_r && going_down_r))
    else $error("tap changer travelling both ways");

  a_in_band_idle: assert property (@(posedge clk) disable iff (!rst_n)
    band_r == BAND_IN |-> !going_up_r && !going_down_r)
    else $error("direction held while in band");

  a_tap_raise: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.tap_raised && !tap_load.load |=> tap_now_r == $past(tap_now_r) + 8'sd1)
    else $error("tap raise not applied");

  a_tap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step && !tap_load.load |=> $stable(tap_now_r))
    else $error("tap moved without a request");

endmodule

// ----- hdl/ratio_tap_changer_controller.sv -----
// ----------------------------------------------------------------------------
// ratio_tap_changer_controller
// On-load tap changer voltage regulator, one evaluation per request.
// ----------------------------------------------------------------------------
// usage
//   in_*  : one request per transfer, time stamp, voltage, offset and flags
//   out_* : one result per request, tap position, move flags, band status
//   cfg_* : register writes, always ready; the user must make them only while
//     the block is idle, as the block itself does not enforce it
// path: a request passes the input register, then the result register
// throughput: one request per cycle while results are taken; the regulator
//   state is updated as a request moves from the input to the result register
// a stalled receiver holds the result register; the input register still
//   takes one more request, then in_tready drops until the result is taken
// reset: registers return to their defaults, tap at zero, both directions
//   idle, references at minus one, band status in band, no result pending
// ----------------------------------------------------------------------------
module ratio_tap_changer_controller import rtcc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // now[31:0], voltage[47:32], target_offset[63:48], node_off[64],
  // disabled[65], locked[66], transformer_closed[67], events_off[68]
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // tap_position[7:0], tap_raised[8], tap_lowered[9], band_status[11:10]
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  item_t       in_item;
  item_t       item_r;
  logic        item_valid_r;
  result_t     result;
  result_t     out_r;
  logic        out_valid_r;
  logic        advance;
  cfg_t        cfg;
  tap_load_t   tap_load;
  band_flags_t flags;

  assign in_item.now                = in_tdata[31:0];
  assign in_item.voltage            = in_tdata[47:32];
  assign in_item.target_offset      = $signed(in_tdata[63:48]);
  assign in_item.node_off           = in_tdata[64];
  assign in_item.disabled           = in_tdata[65];
  assign in_item.locked             = in_tdata[66];
  assign in_item.transformer_closed = in_tdata[67];
  assign in_item.events_off         = in_tdata[68];

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign cfg_ready = 1'b1;

  rtcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .tap_load (tap_load)
  );

  rtcc_band u_band (
    .cfg   (cfg),
    .item  (item_r),
    .flags (flags)
  );

  rtcc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (item_r),
    .cfg      (cfg),
    .flags    (flags),
    .tap_load (tap_load),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.band_status, out_r.tap_lowered, out_r.tap_raised,
                       out_r.tap_position};

endmodule

// ----- tb/ratio_tap_changer_controller_tb.sv -----
// ----------------------------------------------------------------------------
// ratio_tap_changer_controller_tb
// Self-checking bench for the tap changer regulator. A directed run covers
// the reset settings, field and register extremes, blocking flags, time wrap
// and long delays. Phases of random excursions above, below and inside the
// band then follow, each under new settings. Requests and results stall at
// random, and an in-bench regulator predicts every result.
// ----------------------------------------------------------------------------
module ratio_tap_changer_controller_tb;
  import rtcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  // flag sets, {events_off, transformer_closed, locked, disabled, node_off}
  localparam logic [4:0] FL_CLEAN      = 5'b01000;
  localparam logic [4:0] FL_LOCKED     = 5'b01100;
  localparam logic [4:0] FL_DISABLED   = 5'b01010;
  localparam logic [4:0] FL_NODE_OFF   = 5'b01001;
  localparam logic [4:0] FL_EVENTS_OFF = 5'b11000;
  localparam logic [4:0] FL_OPEN       = 5'b00000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  ratio_tap_changer_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // regulator settings
  logic [15:0] set_point   = 16'd0;
  logic [13:0] half_band   = TOLERANCE_RESET;
  logic [23:0] first_wait  = 24'd0;
  logic [23:0] next_wait   = 24'd0;
  logic        regulate_on = 1'b1;
  logic        up_raises   = 1'b0;

  // regulator state
  logic signed [7:0] tap_pos     = 8'sd0;
  logic [31:0]       rise_since  = '0;
  logic              rise_ok     = 1'b0;
  logic [31:0]       fall_since  = '0;
  logic              fall_ok     = 1'b0;
  logic [31:0]       moved_at    = '0;
  logic              moved_ok    = 1'b0;
  logic              raising     = 1'b0;
  logic              lowering    = 1'b0;
  logic signed [7:0] rise_ref    = TAP_REF_RESET;
  logic signed [7:0] fall_ref    = TAP_REF_RESET;
  band_t             band        = BAND_IN;

  item_t   pending_requests[$];
  result_t due_results[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  logic    in_took     = 1'b0;
  int      burst_left  = 1;
  int      gap_left    = 0;
  logic [31:0] stall_pat = '0;
  logic [4:0]  stall_pos = '0;

  function automatic logic waited(input logic ok, input logic [31:0] since,
                                  input logic [31:0] now, input logic [23:0] delay);
    logic [31:0] span;
    span = now - since;
    return ok && (span >= {8'd0, delay});
  endfunction

  function automatic void clear_rise();
    rise_since = '0;
    rise_ok    = 1'b0;
    raising    = 1'b0;
    rise_ref   = LOW_TAP;
  endfunction

  function automatic void clear_fall();
    fall_since = '0;
    fall_ok    = 1'b0;
    lowering   = 1'b0;
    fall_ref   = HIGH_TAP;
  endfunction

  function automatic void start_rise(input logic [31:0] now);
    rise_since = now;
    rise_ok    = 1'b1;
    raising    = 1'b1;
    rise_ref   = tap_pos;
    clear_fall();
  endfunction

  function automatic void start_fall(input logic [31:0] now);
    fall_since = now;
    fall_ok    = 1'b1;
    lowering   = 1'b1;
    fall_ref   = tap_pos;
    clear_rise();
  endfunction

  // one evaluation of the regulator, conditions taken from the state before it
  function automatic result_t regulate(input item_t it);
    int      upper;
    int      lower;
    int      volt;
    logic    live;
    logic    above;
    logic    below;
    logic    allow;
    logic    up_due;
    logic    down_due;
    result_t res;
    upper    = int'(set_point) + int'(half_band) + int'(it.target_offset);
    lower    = int'(set_point) - int'(half_band) + int'(it.target_offset);
    volt     = int'(it.voltage);
    live     = !it.node_off && it.transformer_closed;
    above    = (volt > upper) && !it.disabled && live;
    below    = (volt < lower) && !it.disabled && live;
    allow    = !it.locked && regulate_on && live;
    up_due   = raising && allow && (tap_pos < HIGH_TAP) &&
               ((tap_pos == rise_ref) ? waited(rise_ok, rise_since, it.now, first_wait)
                                      : waited(moved_ok, moved_at, it.now, next_wait));
    down_due = lowering && allow && (tap_pos > LOW_TAP) &&
               ((tap_pos == fall_ref) ? waited(fall_ok, fall_since, it.now, first_wait)
                                      : waited(moved_ok, moved_at, it.now, next_wait));
    res.tap_raised  = 1'b0;
    res.tap_lowered = 1'b0;
    if (!it.disabled && live && !it.locked && !it.events_off) begin
      if (above && band != BAND_ABOVE) begin
        if (!up_raises) start_rise(it.now);
        else start_fall(it.now);
        band = BAND_ABOVE;
      end
      if (below && band != BAND_BELOW) begin
        if (!up_raises) start_fall(it.now);
        else start_rise(it.now);
        band = BAND_BELOW;
      end
      if (!above && !below && band != BAND_IN) begin
        clear_rise();
        clear_fall();
        band = BAND_IN;
      end
      if (up_due) begin
        tap_pos        = tap_pos + 8'sd1;
        moved_at       = it.now;
        moved_ok       = 1'b1;
        res.tap_raised = 1'b1;
      end
      if (down_due) begin
        tap_pos         = tap_pos - 8'sd1;
        moved_at        = it.now;
        moved_ok        = 1'b1;
        res.tap_lowered = 1'b1;
      end
    end
    res.tap_position = tap_pos;
    res.band_status  = band;
    return res;
  endfunction

  function automatic logic [InDataW-1:0] pack_request(input item_t it);
    return {3'b000, it.events_off, it.transformer_closed, it.locked, it.disabled,
            it.node_off, it.target_offset, it.voltage, it.now};
  endfunction

  task automatic queue_request(input logic [31:0] now, input logic [15:0] volt,
                               input logic [15:0] offset, input logic [4:0] flags);
    item_t it;
    it.now                = now;
    it.voltage            = volt;
    it.target_offset      = offset;
    it.node_off           = flags[0];
    it.disabled           = flags[1];
    it.locked             = flags[2];
    it.transformer_closed = flags[3];
    it.events_off         = flags[4];
    pending_requests.push_back(it);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TARGET_VOLTAGE:    set_point   = value[15:0];
      CFG_TOLERANCE:         half_band   = value[13:0];
      CFG_FIRST_DELAY:       first_wait  = value;
      CFG_NEXT_DELAY:        next_wait   = value;
      CFG_INITIAL_TAP:       tap_pos     = signed'(value[7:0]);
      CFG_REGULATING:        regulate_on = value[0];
      CFG_UP_RAISES_VOLTAGE: up_raises   = value[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] target, input logic [13:0] tol,
                              input logic [23:0] first, input logic [23:0] next,
                              input logic [7:0] tap, input logic regul,
                              input logic up_r, input logic with_tap,
                              input logic stray);
    write_reg(CFG_TARGET_VOLTAGE, {8'd0, target});
    write_reg(CFG_TOLERANCE, {10'd0, tol});
    write_reg(CFG_FIRST_DELAY, first);
    write_reg(CFG_NEXT_DELAY, next);
    if (with_tap) write_reg(CFG_INITIAL_TAP, {16'd0, tap});
    write_reg(CFG_REGULATING, {23'd0, regul});
    write_reg(CFG_UP_RAISES_VOLTAGE, {23'd0, up_r});
    if (stray) write_reg(CFG_UNUSED, 24'hFFFFFF);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver, bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      in_took = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pack_request(pending_requests[0]);
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      due_results.push_back(regulate(pending_requests[0]));
      pending_requests.delete(0);
      in_took = 1'b1;
    end
  end

  // result stalls, pattern reloaded each time stall_pos wraps to zero
  always @(negedge clk) begin
    if (stall_pos == 5'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '0;
        1:       stall_pat = $urandom & $urandom;
        2:       stall_pat = $urandom;
        default: stall_pat = $urandom | $urandom;
      endcase
    end
    out_tready <= !stall_pat[stall_pos];
    stall_pos  = stall_pos + 5'd1;
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.tap_position = out_tdata[7:0];
      got.tap_raised   = out_tdata[8];
      got.tap_lowered  = out_tdata[9];
      got.band_status  = band_t'(out_tdata[11:10]);
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tap %0d raised %b lowered %b band %0d",
                   got.tap_position, got.tap_raised, got.tap_lowered, got.band_status);
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (got.tap_position !== want.tap_position || got.tap_raised !== want.tap_raised ||
            got.tap_lowered !== want.tap_lowered || got.band_status !== want.band_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch (exp/got): tap %0d/%0d raised %b/%b lowered %b/%b band %0d/%0d",
                     want.tap_position, got.tap_position, want.tap_raised, got.tap_raised,
                     want.tap_lowered, got.tap_lowered, want.band_status, got.band_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          n;
    int          k;
    int          seg_len;
    int          off;
    int          upper;
    int          lower;
    int          base;
    int          vol;
    int          step_max;
    int          sel;
    band_t       aim;
    logic [31:0] ticks;
    logic [15:0] r_target;
    logic [13:0] r_tol;
    logic [23:0] r_first;
    logic [23:0] r_next;
    logic [7:0]  r_tap;
    logic [4:0]  flags;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: moves, blocking flags, offset extremes, time wrap
    queue_request(32'd0, 16'd0, 16'd0, FL_CLEAN);
    queue_request(32'd5, 16'hFFFF, 16'd0, FL_CLEAN);
    queue_request(32'd6, 16'hFFFF, 16'd0, FL_CLEAN);
    queue_request(32'd6, 16'hFFFF, 16'd0, FL_CLEAN);
    queue_request(32'd6, 16'hFFFF, 16'd0, FL_LOCKED);
    queue_request(32'd7, 16'hFFFF, 16'd0, FL_EVENTS_OFF);
    queue_request(32'd7, 16'hFFFF, 16'd0, FL_DISABLED);
    queue_request(32'd7, 16'hFFFF, 16'd0, FL_NODE_OFF);
    queue_request(32'd8, 16'hFFFF, 16'd0, FL_OPEN);
    queue_request(32'hFFFF_FFFF, 16'hFFFF, 16'd0, FL_CLEAN);
    queue_request(32'd0, 16'd0, 16'h7FFF, FL_CLEAN);
    queue_request(32'd1, 16'd0, 16'h7FFF, FL_CLEAN);
    queue_request(32'd1, 16'hFFFF, 16'h8000, FL_CLEAN);
    queue_request(32'd2, 16'd246, 16'd0, FL_CLEAN);
    wait_idle();

    // register maxima, tap above the upper limit, longest delays
    program_regs(16'hFFFF, 14'h3FFF, 24'hFFFFFF, 24'hFFFFFF, 8'h7F, 1'b1, 1'b1,
                 1'b1, 1'b1);
    queue_request(32'd0, 16'd0, 16'd0, FL_CLEAN);
    queue_request(32'h0100_0000, 16'hFFFF, 16'h8000, FL_CLEAN);
    queue_request(32'h01FF_FFFF, 16'hFFFF, 16'h8000, FL_CLEAN);
    queue_request(32'h02FF_FFFE, 16'hFFFF, 16'h8000, FL_CLEAN);
    queue_request(32'h02FF_FFFF, 16'hFFFF, 16'h8000, FL_CLEAN);
    wait_idle();

    // register minima, lowest tap, regulation off then on
    program_regs(16'd0, 14'd0, 24'd0, 24'd0, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_request(32'd0, 16'd1, 16'd0, FL_CLEAN);
    queue_request(32'd1, 16'd1, 16'd0, FL_CLEAN);
    wait_idle();
    program_regs(16'd0, 14'd0, 24'd0, 24'd0, 8'h80, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_request(32'd0, 16'd1, 16'd0, FL_CLEAN);
    queue_request(32'd1, 16'd1, 16'd0, FL_CLEAN);
    queue_request(32'd2, 16'd0, 16'd0, FL_CLEAN);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      r_target = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(12000, 20000));
      sel = $urandom_range(0, 15);
      r_tol = (sel == 0) ? 14'd0 : (sel == 1) ? 14'h3FFF : 14'($urandom_range(0, 800));
      if (ph == 5) begin
        r_first = 24'($urandom);
        r_next  = 24'($urandom);
      end else begin
        r_first = 24'($urandom_range(0, 40));
        r_next  = 24'($urandom_range(0, 40));
      end
      r_tap = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(int'($urandom_range(0, 38)) - 4);
      program_regs(r_target, r_tol, r_first, r_next, r_tap, $urandom_range(0, 4) != 0,
                   1'($urandom), (ph == 0) || ($urandom_range(0, 1) == 1), 1'b0);
      ticks    = (ph == 2) ? 32'hFFFF_FF00 : $urandom;
      step_max = int'((r_first > r_next) ? r_first : r_next) / 4 + 2;
      n = 0;
      while (n < PHASE_ITEMS) begin
        case ($urandom_range(0, 2))
          0:       aim = BAND_IN;
          1:       aim = BAND_ABOVE;
          default: aim = BAND_BELOW;
        endcase
        seg_len = $urandom_range(1, 60);
        off = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 400)) - 200 : 0;
        for (k = 0; k < seg_len && n < PHASE_ITEMS; k++) begin
          ticks = ticks + $urandom_range(0, step_max);
          upper = int'(set_point) + int'(half_band) + off;
          lower = int'(set_point) - int'(half_band) + off;
          case (aim)
            BAND_ABOVE: begin
              base = (upper < 0) ? 0 : upper + 1;
              if (base > 65535) vol = 65535;
              else vol = base + $urandom_range(0, (65535 - base < 300) ? 65535 - base : 300);
            end
            BAND_BELOW: begin
              base = (lower > 65536) ? 65535 : lower - 1;
              if (base < 0) vol = 0;
              else vol = base - $urandom_range(0, (base < 300) ? base : 300);
            end
            default: begin
              base = (lower < 0) ? 0 : lower;
              vol  = (upper > 65535) ? 65535 : upper;
              if (base <= vol) vol = base + $urandom_range(0, vol - base);
              else vol = $urandom_range(0, 65535);
            end
          endcase
          flags = ($urandom_range(0, 19) == 0) ? 5'($urandom) : FL_CLEAN;
          // occasional noise, every field at random
          if ($urandom_range(0, 39) == 0)
            queue_request($urandom, 16'($urandom), 16'($urandom), 5'($urandom));
          else
            queue_request(ticks, 16'(vol), 16'(off), flags);
          n++;
        end
      end
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rtcc_pkg.sv
hdl/rtcc_cfg.sv
hdl/rtcc_band.sv
hdl/rtcc_core.sv
hdl/ratio_tap_changer_controller.sv
tb/ratio_tap_changer_controller_tb.sv
